[sv/vhsn_pkg.sv]
// Shared types, constants and helpers for the three-axis Holt smoother.
package vhsn_pkg;

    localparam int AXES_DEF = 3;
    localparam int AXES_MAX = 4;
    localparam logic signed [31:0] ONE_Q16 = 32'sd65536;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    localparam logic [0:0] KIND_SMOOTH = 1'b0;
    localparam logic [0:0] KIND_FORCE  = 1'b1;

    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_BETA  = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] sample_x;
        logic signed [31:0] sample_y;
        logic signed [31:0] sample_z;
        logic        [23:0] time_step;
        logic               normalize_flag;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] level_x;
        logic signed [31:0] level_y;
        logic signed [31:0] level_z;
    } t_out_item;

    // Lane command from the sequencer.
    typedef struct packed {
        logic               start_a;   // phase 1: smoothed value
        logic               start_b;   // phase 2: trend and level
        logic               force_ld;  // load sample, clear trend
        logic               norm_ld;   // write normalized level
        logic signed [17:0] gain_a;    // 0..65536
        logic signed [17:0] gain_b;
    } t_lane_cmd;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'(S32_MAX)) return S32_MAX;
        if (v < 64'(S32_MIN)) return S32_MIN;
        return v[31:0];
    endfunction

    // floor(v / 65536) for signed values
    function automatic logic signed [63:0] fl16(input logic signed [63:0] v);
        return v >>> 16;
    endfunction

endpackage

[sv/vhsn_lane.sv]
// One axis of the smoother: smoothed value, trend and level registers.
module vhsn_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  vhsn_pkg::t_lane_cmd   i_cmd,
    input  logic signed [31:0]    i_sample,
    input  logic signed [31:0]    i_norm_level,
    output logic signed [31:0]    o_level
);
    import vhsn_pkg::*;

    logic signed [31:0] r_level, r_smooth, r_trend, r_old_sm;
    logic signed [63:0] diff_a, prod_a, diff_b, prod_b;
    logic signed [31:0] n_smooth, n_trend;

    // 33-bit difference times 17-bit gain fits in 64 bits
    always_comb begin
        diff_a   = 64'(i_sample) - 64'(r_level);
        prod_a   = diff_a * 64'(i_cmd.gain_a);
        n_smooth = sat32(64'(r_level) + fl16(prod_a));
        diff_b   = (64'(r_smooth) - 64'(r_old_sm)) - 64'(r_trend);
        prod_b   = diff_b * 64'(i_cmd.gain_b);
        n_trend  = sat32(64'(r_trend) + fl16(prod_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_smooth <= '0;
            r_trend  <= '0;
            r_old_sm <= '0;
        end else if (i_cmd.force_ld) begin
            r_level  <= i_sample;
            r_smooth <= i_sample;
            r_trend  <= '0;
        end else if (i_cmd.start_a) begin
            r_old_sm <= r_smooth;
            r_smooth <= n_smooth;
        end else if (i_cmd.start_b) begin
            r_trend <= n_trend;
            r_level <= sat32(64'(n_trend) + 64'(r_smooth));
        end else if (i_cmd.norm_ld) begin
            r_level  <= i_norm_level;
            r_smooth <= i_norm_level;
            r_trend  <= '0;
        end
    end

    assign o_level = r_level;
endmodule

[sv/vhsn_norm.sv]
// Merge stage: sum of squares, bit-serial square root, serial divides.
module vhsn_norm #(
    parameter int AXES = vhsn_pkg::AXES_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [31:0]      i_level [AXES],
    output logic                    o_done,
    output logic signed [31:0]      o_level [AXES]
);
    import vhsn_pkg::*;

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SUM  = 6'b000010,
        ST_SQRT = 6'b000100,
        ST_DIVS = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state             r_state;
    logic [AW:0]        r_idx;
    logic [63:0]        r_sum;
    logic [63:0]        r_rem, r_root, r_bit;
    logic [31:0]        r_len;
    logic [5:0]         r_cnt;
    logic [47:0]        r_num;     // |level| << 16
    logic [48:0]        r_drem;
    logic [47:0]        r_quot;
    logic               r_neg;
    logic signed [31:0] r_out [AXES];

    logic [31:0] abs_v;
    logic [63:0] sq;
    logic [64:0] sum_w;
    logic [63:0] trial;
    logic [48:0] dr_sh;
    logic [AW-1:0] ix;

    function automatic logic signed [63:0] q_s_last(input logic neg, input logic [47:0] q,
                                                     input logic b);
        logic [48:0] qq;
        qq = {q, b};
        return neg ? -$signed({15'd0, qq}) : $signed({15'd0, qq});
    endfunction

    always_comb begin
        ix    = r_idx[AW-1:0];
        abs_v = i_level[ix][31] ? 32'(-i_level[ix]) : i_level[ix];
        sq    = 64'(abs_v) * 64'(abs_v);
        sum_w = 65'(r_sum) + 65'(sq);
        trial = r_root + r_bit;
        dr_sh = {r_drem[47:0], r_num[47]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: if (i_start) begin
                    r_state <= ST_SUM;
                    r_idx   <= '0;
                    r_sum   <= '0;
                end
                ST_SUM: begin
                    r_sum <= sum_w[64] ? '1 : sum_w[63:0];
                    if (r_idx == (AW+1)'(AXES - 1)) begin
                        r_state <= ST_SQRT;
                        r_rem   <= sum_w[64] ? '1 : sum_w[63:0];
                        r_root  <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_SQRT: begin
                    // one result bit per cycle
                    if (r_rem >= trial) begin
                        r_rem  <= r_rem - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) begin
                        r_state <= ST_DIVS;
                        r_idx   <= '0;
                    end
                end
                ST_DIVS: begin
                    r_len <= r_root[31:0];
                    if (r_root == '0) begin
                        for (int k = 0; k < AXES; k++) r_out[k] <= i_level[k];
                        r_state <= ST_DONE;
                    end else begin
                        r_neg   <= i_level[ix][31];
                        r_num   <= {abs_v, 16'd0};
                        r_drem  <= '0;
                        r_quot  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_num <= r_num << 1;
                    if (dr_sh >= 49'(r_len)) begin
                        r_drem <= dr_sh - 49'(r_len);
                        r_quot <= {r_quot[46:0], 1'b1};
                    end else begin
                        r_drem <= dr_sh;
                        r_quot <= {r_quot[46:0], 1'b0};
                    end
                    if (r_cnt == 6'd47) begin
                        r_out[ix] <= sat32(64'(q_s_last(r_neg, r_quot, dr_sh >= 49'(r_len))));
                        r_idx     <= r_idx + 1'b1;
                        if (r_idx == (AW+1)'(AXES - 1)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_DIVS;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_DONE: r_state <= ST_IDLE;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == ST_DONE);
    assign o_level = r_out;
endmodule

[sv/vec3_holt_smoother_normalize_core.sv]
// Top level of the three-axis Holt double exponential smoother.
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in): one item per
//   sample. kind selects smoothing or a force load of all axes.
//   Output channel (o_out_valid / i_out_stall, payload o_out): one item per
//   input item, the level vector after the step.
//   Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write alpha and beta gains
//   while the block is idle.
// Sequence:
//   A plain smooth runs gain scale, then the lanes run two phases (smoothed
//   value, then trend and level) with one shared gain per phase, then the
//   output load. A force item runs gain scale, which loads the lanes, and
//   then the output load. With normalization the merge stage runs after the
//   second phase: sum of squares, bit-serial square root, then a serial
//   divide per axis.
//   One item is in work at a time; the next is accepted as soon as the
//   sequencer is idle. A finished item waits while the output register holds.
// Reset: clears all levels, smoothed values, trends and both gains.
// Stall: a result held by i_out_stall blocks the next finished item, and
//   with it the input.
module vec3_holt_smoother_normalize_core #(
    parameter int AXES = vhsn_pkg::AXES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  vhsn_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output vhsn_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [23:0]         i_cfg_data
);
    import vhsn_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_GAIN  = 6'b000010,
        S_PH_A  = 6'b000100,
        S_PH_B  = 6'b001000,
        S_NORM  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state             r_state;
    logic signed [23:0] r_alpha, r_beta;
    t_in_item           r_item;
    logic signed [17:0] r_ga, r_gb;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               r_norm_go;

    t_lane_cmd          cmd;
    logic signed [31:0] lane_lvl  [AXES];
    logic signed [31:0] lane_smp  [AXES];
    logic signed [31:0] norm_lvl  [AXES];
    logic               norm_done;
    logic               in_acc;

    // gain scale: g * dt >> 16, clamped to [0, 1.0]
    function automatic logic signed [17:0] scale_gain(input logic signed [23:0] g,
                                                      input logic [23:0] dt);
        logic signed [48:0] p;
        p = 49'(g) * $signed({25'd0, dt});
        if (p <= 0) return '0;
        if ((p >>> 16) > 49'(ONE_Q16)) return 18'(ONE_Q16);
        return p[33:16];
    endfunction

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0;
            r_beta  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ALPHA: r_alpha <= i_cfg_data;
                REG_BETA:  r_beta  <= i_cfg_data;
                default:   r_alpha <= r_alpha;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_norm_go   <= 1'b0;
        end else begin
            r_norm_go <= 1'b0;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (in_acc) begin
                    r_item  <= i_in;
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_ga    <= scale_gain(r_alpha, r_item.time_step);
                    r_gb    <= scale_gain(r_beta,  r_item.time_step);
                    r_state <= (r_item.kind == KIND_FORCE) ? S_OUT : S_PH_A;
                end
                S_PH_A: r_state <= S_PH_B;
                S_PH_B: begin
                    if (r_item.normalize_flag) begin
                        r_state   <= S_NORM;
                        r_norm_go <= 1'b1;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_NORM: if (norm_done) r_state <= S_OUT;
                S_OUT: if (!r_out_valid) begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result register, loaded as the item leaves
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && !r_out_valid) begin
            r_out.level_x <= lane_lvl[0];
            r_out.level_y <= (AXES > 1) ? lane_lvl[(AXES > 1) ? 1 : 0] : '0;
            r_out.level_z <= (AXES > 2) ? lane_lvl[(AXES > 2) ? 2 : 0] : '0;
        end
    end

    always_comb begin
        cmd.start_a  = (r_state == S_PH_A);
        cmd.start_b  = (r_state == S_PH_B);
        cmd.force_ld = (r_state == S_GAIN) && (r_item.kind == KIND_FORCE);
        cmd.norm_ld  = (r_state == S_NORM) && norm_done;
        cmd.gain_a   = r_ga;
        cmd.gain_b   = r_gb;
        for (int k = 0; k < AXES; k++) begin
            case (k)
                0:       lane_smp[k] = r_item.sample_x;
                1:       lane_smp[k] = r_item.sample_y;
                2:       lane_smp[k] = r_item.sample_z;
                default: lane_smp[k] = '0;
            endcase
        end
    end

    for (genvar g = 0; g < AXES; g++) begin : g_lane
        vhsn_lane u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_sample     (lane_smp[g]),
            .i_norm_level (norm_lvl[g]),
            .o_level      (lane_lvl[g])
        );
    end

    vhsn_norm #(.AXES(AXES)) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_norm_go),
        .i_level (lane_lvl),
        .o_done  (norm_done),
        .o_level (norm_lvl)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule
